// ===== design/gmj_pkg.sv =====
// shared types and constants of the grid metric and jacobian block
package gmj_pkg;

  // field widths of the item, result and register write channels
  localparam int RowIdxW  = 6;
  localparam int ColIdxW  = 6;
  localparam int CoordW   = 24;
  localparam int DiffW    = CoordW + 1;
  localparam int MetricW  = 26;
  localparam int JacW     = 2 * MetricW;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 7;

  // smallest grid size the stencils work on
  localparam int MinSize = 3;

  // register reset values
  localparam logic [CfgDataW-1:0] RowsReset = 7'd64;
  localparam logic [CfgDataW-1:0] ColsReset = 7'd64;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_IDX_ROWS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IDX_COLS = 2'd1;

  // item command codes
  typedef enum logic [0:0] {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } gmj_cmd_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_XI,
    ST_RD_ETA,
    ST_DIFF_ETA,
    ST_MUL_A,
    ST_MUL_B,
    ST_FINISH
  } gmj_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load_start;
    logic query_start;
    logic rd_eta;
    logic latch_xi;
    logic latch_eta;
    logic mul_first;
    logic mul_second;
    logic out_load;
  } gmj_ctrl_t;

  // datapath to controller status
  typedef struct packed {
    logic in_is_query;
  } gmj_stat_t;

endpackage

// ===== design/gmj_if.sv =====
// valid/ready channel interfaces for items, results and register writes

// input item channel
interface gmj_item_if;
  logic                                   valid;
  logic                                   ready;
  gmj_pkg::gmj_cmd_e                      command;
  logic        [gmj_pkg::RowIdxW-1:0]     row_index;
  logic        [gmj_pkg::ColIdxW-1:0]     col_index;
  logic signed [gmj_pkg::CoordW-1:0]      x_coord;
  logic signed [gmj_pkg::CoordW-1:0]      y_coord;

  modport source (output valid, command, row_index, col_index, x_coord, y_coord,
                  input ready);
  modport sink (input valid, command, row_index, col_index, x_coord, y_coord,
                output ready);
endinterface

// result channel
interface gmj_result_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [gmj_pkg::JacW-1:0]        jacobian;
  logic signed [gmj_pkg::MetricW-1:0]     metric_xx;
  logic signed [gmj_pkg::MetricW-1:0]     metric_xy;
  logic signed [gmj_pkg::MetricW-1:0]     metric_yx;
  logic signed [gmj_pkg::MetricW-1:0]     metric_yy;
  logic                                   index_error;

  modport source (output valid, jacobian, metric_xx, metric_xy, metric_yx, metric_yy,
                  index_error, input ready);
  modport sink (input valid, jacobian, metric_xx, metric_xy, metric_yx, metric_yy,
                index_error, output ready);
endinterface

// register write channel
interface gmj_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [gmj_pkg::CfgIdxW-1:0]       index;
  logic [gmj_pkg::CfgDataW-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/grid_metric_jacobian_top.sv =====
// top level of the grid metric and jacobian block
//
//  channel   | role  | handshake     | payload
//  ----------+-------+---------------+---------------------------------------------
//  item_i    | sink  | valid / ready | command, row_index, col_index, x/y_coord
//  result_o  | source| valid / ready | jacobian, metric_xx/xy/yx/yy, index_error
//  cfg_i     | sink  | valid / ready | index (0 rows_in_use, 1 cols_in_use), data
//
// a load item is written in its accept cycle; the next item is taken in the following cycle.
// a query item holds the input through the accept cycle, two reads on the
// two memory read ports (xi difference taken during the eta read), a step for the eta
// difference, two steps on the shared 26x26 multiplier and a step to load the result
// register, whose valid flag is registered; it stalls there until the
// previous result is taken. reset clears the controller and sets both sizes to 64.
module grid_metric_jacobian_top #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  gmj_item_if.sink       item_i,
  gmj_result_if.source   result_o,
  gmj_cfg_if.sink        cfg_i
);

  gmj_pkg::gmj_ctrl_t ctrl;
  gmj_pkg::gmj_stat_t stat;

  // register writes are always taken
  assign cfg_i.ready = 1'b1;

  // controller
  gmj_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // datapath
  gmj_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .cfg_we_i      (cfg_i.valid && cfg_i.ready),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .command_i     (item_i.command),
    .row_index_i   (item_i.row_index),
    .col_index_i   (item_i.col_index),
    .x_coord_i     (item_i.x_coord),
    .y_coord_i     (item_i.y_coord),
    .jacobian_o    (result_o.jacobian),
    .metric_xx_o   (result_o.metric_xx),
    .metric_xy_o   (result_o.metric_xy),
    .metric_yx_o   (result_o.metric_yx),
    .metric_yy_o   (result_o.metric_yy),
    .index_error_o (result_o.index_error)
  );

endmodule

// ===== design/gmj_ram.sv =====
// generic ram: one write port, two read ports with registered read data
module gmj_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read ports
  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== design/gmj_ctrl.sv =====
// controller state machine: sequences loads, stencil reads, products and result
module gmj_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  gmj_pkg::gmj_stat_t stat_i,
  output gmj_pkg::gmj_ctrl_t ctrl_o
);

  gmj_pkg::gmj_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                accept;

  // state and result valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gmj_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = (state_q == gmj_pkg::ST_IDLE);
    accept     = in_valid_i && in_ready_o;
    case (state_q)
      gmj_pkg::ST_IDLE: begin
        if (accept) begin
          if (stat_i.in_is_query) begin
            ctrl_o.query_start = 1'b1;
            state_d            = gmj_pkg::ST_RD_XI;
          end else begin
            ctrl_o.load_start = 1'b1;
          end
        end
      end
      gmj_pkg::ST_RD_XI: begin
        state_d = gmj_pkg::ST_RD_ETA;
      end
      gmj_pkg::ST_RD_ETA: begin
        ctrl_o.rd_eta   = 1'b1;
        ctrl_o.latch_xi = 1'b1;
        state_d         = gmj_pkg::ST_DIFF_ETA;
      end
      gmj_pkg::ST_DIFF_ETA: begin
        ctrl_o.latch_eta = 1'b1;
        state_d          = gmj_pkg::ST_MUL_A;
      end
      gmj_pkg::ST_MUL_A: begin
        ctrl_o.mul_first = 1'b1;
        state_d          = gmj_pkg::ST_MUL_B;
      end
      gmj_pkg::ST_MUL_B: begin
        ctrl_o.mul_second = 1'b1;
        state_d           = gmj_pkg::ST_FINISH;
      end
      gmj_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.out_load = 1'b1;
          state_d         = gmj_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gmj_pkg::ST_IDLE;
      end
    endcase
  end

  // result valid: set on load, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== design/gmj_dp.sv =====
// datapath: size registers, coordinate memories, stencil differences, jacobian
module gmj_dp #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  gmj_pkg::gmj_ctrl_t                   ctrl_i,
  output gmj_pkg::gmj_stat_t                   stat_o,
  // register writes
  input  logic                                 cfg_we_i,
  input  logic        [gmj_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic        [gmj_pkg::CfgDataW-1:0]  cfg_data_i,
  // item payload
  input  gmj_pkg::gmj_cmd_e                    command_i,
  input  logic        [gmj_pkg::RowIdxW-1:0]   row_index_i,
  input  logic        [gmj_pkg::ColIdxW-1:0]   col_index_i,
  input  logic signed [gmj_pkg::CoordW-1:0]    x_coord_i,
  input  logic signed [gmj_pkg::CoordW-1:0]    y_coord_i,
  // result payload
  output logic signed [gmj_pkg::JacW-1:0]      jacobian_o,
  output logic signed [gmj_pkg::MetricW-1:0]   metric_xx_o,
  output logic signed [gmj_pkg::MetricW-1:0]   metric_xy_o,
  output logic signed [gmj_pkg::MetricW-1:0]   metric_yx_o,
  output logic signed [gmj_pkg::MetricW-1:0]   metric_yy_o,
  output logic                                 index_error_o
);

  localparam int Depth = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(Depth);
  localparam int RowSW = ($clog2(MAX_ROWS + 1) > gmj_pkg::CfgDataW) ?
                         $clog2(MAX_ROWS + 1) : gmj_pkg::CfgDataW;
  localparam int ColSW = ($clog2(MAX_COLS + 1) > gmj_pkg::CfgDataW) ?
                         $clog2(MAX_COLS + 1) : gmj_pkg::CfgDataW;
  localparam int SW    = (RowSW > ColSW) ? RowSW : ColSW;
  localparam int MW    = gmj_pkg::MetricW;
  localparam int DW    = gmj_pkg::DiffW;
  localparam int CW    = gmj_pkg::CoordW;
  localparam int JW    = gmj_pkg::JacW;

  localparam logic [SW-1:0] MaxRowsS = SW'(MAX_ROWS);
  localparam logic [SW-1:0] MaxColsS = SW'(MAX_COLS);
  localparam logic [SW-1:0] MinS     = SW'(gmj_pkg::MinSize);
  localparam logic [SW-1:0] OneS     = SW'(1);
  localparam logic [SW-1:0] TwoS     = SW'(2);
  localparam logic [AW-1:0] ColsA    = AW'(MAX_COLS);

  // signed difference of two stored coordinates, exact in one extra bit
  function automatic logic signed [DW-1:0] coord_diff(input logic [CW-1:0] hi,
                                                      input logic [CW-1:0] lo);
    logic signed [DW-1:0] hi_s;
    logic signed [DW-1:0] lo_s;
    hi_s = $signed({hi[CW-1], hi});
    lo_s = $signed({lo[CW-1], lo});
    return hi_s - lo_s;
  endfunction

  logic [gmj_pkg::CfgDataW-1:0] rows_q, cols_q;
  logic [SW-1:0]                nj, nk, rows_ext, cols_ext, j_s, k_s;
  logic [SW-1:0]                xi_lo_row, xi_hi_row, eta_lo_col, eta_hi_col;
  logic                         one_sided, query_err, load_in_range;
  logic [AW-1:0]                load_addr;
  logic [AW-1:0]                xi_lo_d, xi_hi_d, eta_lo_d, eta_hi_d;
  logic [AW-1:0]                xi_lo_q, xi_hi_q, eta_lo_q, eta_hi_q;
  logic                         one_sided_q, err_q;
  logic [AW-1:0]                raddr_a, raddr_b;
  logic [CW-1:0]                x_rd_a, x_rd_b, y_rd_a, y_rd_b;
  logic signed [DW-1:0]         x_diff, y_diff;
  logic signed [MW-1:0]         xxsi_q, yxsi_q, xeta_q, yeta_q;
  logic signed [MW-1:0]         op_a, op_b;
  logic signed [JW-1:0]         prod;
  logic signed [JW-1:0]         p0_q, p1_q;
  logic signed [JW-1:0]         jac_q;
  logic signed [MW-1:0]         mxx_q, mxy_q, myx_q, myy_q;
  logic                         ierr_q;

  assign stat_o.in_is_query = (command_i == gmj_pkg::CMD_QUERY);

  // size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= gmj_pkg::RowsReset;
      cols_q <= gmj_pkg::ColsReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == gmj_pkg::CFG_IDX_ROWS) begin
        rows_q <= cfg_data_i;
      end else if (cfg_index_i == gmj_pkg::CFG_IDX_COLS) begin
        cols_q <= cfg_data_i;
      end
    end
  end

  // effective sizes, clamped to the stencil minimum and the memory bounds
  always_comb begin
    rows_ext = SW'(rows_q);
    cols_ext = SW'(cols_q);
    if (rows_ext < MinS) begin
      nj = MinS;
    end else if (rows_ext > MaxRowsS) begin
      nj = MaxRowsS;
    end else begin
      nj = rows_ext;
    end
    if (cols_ext < MinS) begin
      nk = MinS;
    end else if (cols_ext > MaxColsS) begin
      nk = MaxColsS;
    end else begin
      nk = cols_ext;
    end
  end

  // stencil neighbors and addresses of the incoming item
  always_comb begin
    j_s       = SW'(row_index_i);
    k_s       = SW'(col_index_i);
    query_err = (j_s >= nj) || (k_s >= nk);
    // xi: one-sided at both ends, central inside
    if (j_s == '0) begin
      xi_lo_row = '0;
      xi_hi_row = OneS;
      one_sided = 1'b1;
    end else if (j_s == nj - OneS) begin
      xi_lo_row = j_s - OneS;
      xi_hi_row = j_s;
      one_sided = 1'b1;
    end else begin
      xi_lo_row = j_s - OneS;
      xi_hi_row = j_s + OneS;
      one_sided = 1'b0;
    end
    // eta: periodic, both seam points use the points next to the seam
    if (k_s == '0 || k_s == nk - OneS) begin
      eta_hi_col = OneS;
      eta_lo_col = nk - TwoS;
    end else begin
      eta_hi_col = k_s + OneS;
      eta_lo_col = k_s - OneS;
    end
    xi_lo_d       = AW'(AW'(xi_lo_row) * ColsA + AW'(k_s));
    xi_hi_d       = AW'(AW'(xi_hi_row) * ColsA + AW'(k_s));
    eta_lo_d      = AW'(AW'(j_s) * ColsA + AW'(eta_lo_col));
    eta_hi_d      = AW'(AW'(j_s) * ColsA + AW'(eta_hi_col));
    load_addr     = AW'(AW'(j_s) * ColsA + AW'(k_s));
    load_in_range = (j_s < MaxRowsS) && (k_s < MaxColsS);
  end

  // query registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.query_start) begin
      xi_lo_q     <= xi_lo_d;
      xi_hi_q     <= xi_hi_d;
      eta_lo_q    <= eta_lo_d;
      eta_hi_q    <= eta_hi_d;
      one_sided_q <= one_sided;
      err_q       <= query_err;
    end
  end

  // read addresses: xi pair first, then eta pair
  assign raddr_a = ctrl_i.rd_eta ? eta_lo_q : xi_lo_q;
  assign raddr_b = ctrl_i.rd_eta ? eta_hi_q : xi_hi_q;

  // coordinate memories
  gmj_ram #(
    .WIDTH (CW),
    .DEPTH (Depth)
  ) u_x_ram (
    .clk_i     (clk_i),
    .we_i      (ctrl_i.load_start && load_in_range),
    .waddr_i   (load_addr),
    .wdata_i   (x_coord_i),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (x_rd_a),
    .rdata_b_o (x_rd_b)
  );

  gmj_ram #(
    .WIDTH (CW),
    .DEPTH (Depth)
  ) u_y_ram (
    .clk_i     (clk_i),
    .we_i      (ctrl_i.load_start && load_in_range),
    .waddr_i   (load_addr),
    .wdata_i   (y_coord_i),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (y_rd_a),
    .rdata_b_o (y_rd_b)
  );

  // half-differences in q9.17 are the raw q8.16 differences
  assign x_diff = coord_diff(x_rd_b, x_rd_a);
  assign y_diff = coord_diff(y_rd_b, y_rd_a);

  // derivative registers; one-sided xi differences are doubled
  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch_xi) begin
      xxsi_q <= one_sided_q ? {x_diff, 1'b0} : {x_diff[DW-1], x_diff};
      yxsi_q <= one_sided_q ? {y_diff, 1'b0} : {y_diff[DW-1], y_diff};
    end
    if (ctrl_i.latch_eta) begin
      xeta_q <= {x_diff[DW-1], x_diff};
      yeta_q <= {y_diff[DW-1], y_diff};
    end
  end

  // shared multiplier: xxsi*yeta, then xeta*yxsi
  assign op_a = ctrl_i.mul_second ? xeta_q : xxsi_q;
  assign op_b = ctrl_i.mul_second ? yxsi_q : yeta_q;
  assign prod = JW'(op_a) * JW'(op_b);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_first) begin
      p0_q <= prod;
    end
    if (ctrl_i.mul_second) begin
      p1_q <= prod;
    end
  end

  // result register; out-of-range queries give zeros
  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      ierr_q <= err_q;
      if (err_q) begin
        jac_q <= '0;
        mxx_q <= '0;
        mxy_q <= '0;
        myx_q <= '0;
        myy_q <= '0;
      end else begin
        jac_q <= p0_q - p1_q;
        mxx_q <= yeta_q;
        mxy_q <= -xeta_q;
        myx_q <= -yxsi_q;
        myy_q <= xxsi_q;
      end
    end
  end

  assign jacobian_o    = jac_q;
  assign metric_xx_o   = mxx_q;
  assign metric_xy_o   = mxy_q;
  assign metric_yx_o   = myx_q;
  assign metric_yy_o   = myy_q;
  assign index_error_o = ierr_q;

endmodule

// ===== tb/gmj_metrics_checker.sv =====
// checker for the grid metric block: watches the channels, predicts metrics, compares results
module gmj_metrics_checker
  import gmj_pkg::*;
#(
  parameter int MaxRows = 64,
  parameter int MaxCols = 64
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  gmj_item_if   item_i,
  gmj_result_if result_i,
  gmj_cfg_if    cfg_i,
  output int    mismatch_count_o,
  output int    metrics_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // one predicted result item
  typedef struct packed {
    logic signed [JacW-1:0]    jac;
    logic signed [MetricW-1:0] mxx;
    logic signed [MetricW-1:0] mxy;
    logic signed [MetricW-1:0] myx;
    logic signed [MetricW-1:0] myy;
    logic                      err;
  } metrics_t;

  // shadow copy of the coordinate memories and the size registers
  logic signed [CoordW-1:0] x_grid [MaxRows*MaxCols];
  logic signed [CoordW-1:0] y_grid [MaxRows*MaxCols];
  logic [CfgDataW-1:0]      rows_cfg = RowsReset;
  logic [CfgDataW-1:0]      cols_cfg = ColsReset;
  metrics_t                 metrics_due [$];

  function automatic int grid_addr(int j, int k);
    return j * MaxCols + k;
  endfunction

  // sizes below the minimum or above the array bound are clamped
  function automatic int size_in_use(logic [CfgDataW-1:0] raw, int limit);
    if (int'(raw) < MinSize) return MinSize;
    if (int'(raw) > limit) return limit;
    return int'(raw);
  endfunction

  // metrics and jacobian at point (j,k) from the current shadow grid
  function automatic metrics_t grid_metrics_at(int j, int k);
    metrics_t m;
    int       nj, nk, j_hi, j_lo, k_hi, k_lo;
    longint   scale, xxsi, yxsi, xeta, yeta, jac;
    m  = '0;
    nj = size_in_use(rows_cfg, MaxRows);
    nk = size_in_use(cols_cfg, MaxCols);
    if (j >= nj || k >= nk) begin
      m.err = 1'b1;
      return m;
    end
    // xi direction: one-sided at both ends, doubled to keep the half-difference scale
    if (j == 0) begin
      j_hi = 1; j_lo = 0; scale = 2;
    end else if (j == nj - 1) begin
      j_hi = j; j_lo = j - 1; scale = 2;
    end else begin
      j_hi = j + 1; j_lo = j - 1; scale = 1;
    end
    xxsi = scale * (longint'(x_grid[grid_addr(j_hi, k)]) - longint'(x_grid[grid_addr(j_lo, k)]));
    yxsi = scale * (longint'(y_grid[grid_addr(j_hi, k)]) - longint'(y_grid[grid_addr(j_lo, k)]));
    // eta direction: periodic, both seam points use 1 and nk-2
    if (k == 0 || k == nk - 1) begin
      k_hi = 1; k_lo = nk - 2;
    end else begin
      k_hi = k + 1; k_lo = k - 1;
    end
    xeta = longint'(x_grid[grid_addr(j, k_hi)]) - longint'(x_grid[grid_addr(j, k_lo)]);
    yeta = longint'(y_grid[grid_addr(j, k_hi)]) - longint'(y_grid[grid_addr(j, k_lo)]);
    jac  = xxsi * yeta - xeta * yxsi;
    m.jac = JacW'(jac);
    m.mxx = MetricW'(yeta);
    m.mxy = MetricW'(-xeta);
    m.myx = MetricW'(-yxsi);
    m.myy = MetricW'(xxsi);
    return m;
  endfunction

  task automatic check_field(string name, logic signed [JacW-1:0] want,
                             logic signed [JacW-1:0] got);
    if (want !== got) begin
      mismatch_count_o++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // track register writes, compare results, shadow each accepted load, predict on each accepted query
  always @(posedge clk_i or negedge rst_ni) begin : watch
    metrics_t want;
    if (!rst_ni) begin
      metrics_due.delete();
      rows_cfg = RowsReset;
      cols_cfg = ColsReset;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == CFG_IDX_ROWS) rows_cfg = cfg_i.data;
        else if (cfg_i.index == CFG_IDX_COLS) cols_cfg = cfg_i.data;
      end
      if (result_i.valid && result_i.ready) begin
        if (metrics_due.size() == 0) begin
          mismatch_count_o++;
          $display("%0t ns: result item with nothing expected, expected none, actual jacobian %0d",
                   $time, result_i.jacobian);
        end else begin
          want = metrics_due.pop_front();
          check_field("jacobian", want.jac, result_i.jacobian);
          check_field("metric_xx", JacW'(want.mxx), JacW'(result_i.metric_xx));
          check_field("metric_xy", JacW'(want.mxy), JacW'(result_i.metric_xy));
          check_field("metric_yx", JacW'(want.myx), JacW'(result_i.metric_yx));
          check_field("metric_yy", JacW'(want.myy), JacW'(result_i.metric_yy));
          check_field("index_error", JacW'(want.err), JacW'(result_i.index_error));
        end
      end
      if (item_i.valid && item_i.ready) begin
        if (item_i.command == CMD_LOAD) begin
          x_grid[grid_addr(int'(item_i.row_index), int'(item_i.col_index))] = item_i.x_coord;
          y_grid[grid_addr(int'(item_i.row_index), int'(item_i.col_index))] = item_i.y_coord;
        end else begin
          metrics_due.push_back(grid_metrics_at(int'(item_i.row_index),
                                                int'(item_i.col_index)));
        end
      end
    end
    metrics_pending_o = metrics_due.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// testbench top for the grid metric block: clock, reset, stimulus and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gmj_pkg::*;

  localparam int MaxRows     = 64;
  localparam int MaxCols     = 64;
  localparam int RandomItems = 1750;
  localparam int DrainCycles = 12;

  // register indexes past the two sizes, written to see them ignored
  localparam logic [CfgIdxW-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_IDX_SPARE_B = 2'd3;

  localparam logic signed [CoordW-1:0] CoordMax = 24'sh7FFFFF;
  localparam logic signed [CoordW-1:0] CoordMin = 24'sh800000;
  localparam int EdgeSizes [8] = '{0, 1, 2, 3, 63, 64, 65, 127};

  logic clk_i;
  logic rst_ni = 1'b0;
  int   mismatch_count;
  int   metrics_pending;
  int   items_sent;
  bit   items_calm;
  bit   ready_calm;

  // stimulus bookkeeping: raw sizes written and points loaded so far
  logic [CfgDataW-1:0] rows_raw = RowsReset;
  logic [CfgDataW-1:0] cols_raw = ColsReset;
  bit                  loaded [MaxRows][MaxCols];

  gmj_item_if   item_bus ();
  gmj_result_if result_bus ();
  gmj_cfg_if    cfg_bus ();

  grid_metric_jacobian_top #(
    .MAX_ROWS(MaxRows),
    .MAX_COLS(MaxCols)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_bus),
    .result_o(result_bus),
    .cfg_i   (cfg_bus)
  );

  gmj_metrics_checker #(
    .MaxRows(MaxRows),
    .MaxCols(MaxCols)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (item_bus),
    .result_i         (result_bus),
    .cfg_i            (cfg_bus),
    .mismatch_count_o (mismatch_count),
    .metrics_pending_o(metrics_pending)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // mostly no gap, some short ones, a few long ones
  function automatic int idle_len(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [CoordW-1:0] rand_coord();
    int r;
    r = $urandom_range(99);
    if (r < 15) return CoordMax;
    if (r < 30) return CoordMin;
    if (r < 35) return '0;
    return CoordW'($urandom);
  endfunction

  function automatic int size_in_use(logic [CfgDataW-1:0] raw, int limit);
    if (int'(raw) < MinSize) return MinSize;
    if (int'(raw) > limit) return limit;
    return int'(raw);
  endfunction

  // index inside a size, biased toward the ends of the stencil
  function automatic int pick_index(int n);
    int r;
    r = $urandom_range(99);
    if (r < 20) return 0;
    if (r < 40) return n - 1;
    if (r < 50) return 1;
    return $urandom_range(n - 1);
  endfunction

  // small grids mostly, extremes and out-of-range values now and then
  function automatic logic [CfgDataW-1:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 50) return CfgDataW'($urandom_range(3, 12));
    if (r < 75) return CfgDataW'($urandom_range(3, 64));
    return CfgDataW'(EdgeSizes[$urandom_range(7)]);
  endfunction

  // send one item; valid stays high on return so back-to-back items need no gap
  task automatic drive_item(gmj_cmd_e cmd, int j, int k, logic signed [CoordW-1:0] x,
                            logic signed [CoordW-1:0] y);
    int gap;
    gap = idle_len(items_calm);
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_bus.valid     <= 1'b1;
    item_bus.command   <= cmd;
    item_bus.row_index <= RowIdxW'(j);
    item_bus.col_index <= ColIdxW'(k);
    item_bus.x_coord   <= x;
    item_bus.y_coord   <= y;
    do @(posedge clk_i); while (item_bus.ready !== 1'b1);
    if (cmd == CMD_LOAD) loaded[j][k] = 1'b1;
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic ensure_loaded(int j, int k);
    if (!loaded[j][k]) drive_item(CMD_LOAD, j, k, rand_coord(), rand_coord());
  endtask

  // load any stencil point not yet written, then query
  task automatic query_point(int j, int k);
    int nj, nk, j_hi, j_lo, k_hi, k_lo;
    nj = size_in_use(rows_raw, MaxRows);
    nk = size_in_use(cols_raw, MaxCols);
    if (j < nj && k < nk) begin
      if (j == 0) begin
        j_hi = 1; j_lo = 0;
      end else if (j == nj - 1) begin
        j_hi = j; j_lo = j - 1;
      end else begin
        j_hi = j + 1; j_lo = j - 1;
      end
      if (k == 0 || k == nk - 1) begin
        k_hi = 1; k_lo = nk - 2;
      end else begin
        k_hi = k + 1; k_lo = k - 1;
      end
      ensure_loaded(j_hi, k);
      ensure_loaded(j_lo, k);
      ensure_loaded(j, k_hi);
      ensure_loaded(j, k_lo);
    end
    drive_item(CMD_QUERY, j, k, CoordW'($urandom), CoordW'($urandom));
  endtask

  // register write; valid is lowered again once the write is taken
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    repeat (1 + idle_len(items_calm)) @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    if (idx == CFG_IDX_ROWS) rows_raw = value;
    else if (idx == CFG_IDX_COLS) cols_raw = value;
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // stop items, wait for every result, then let a trailing load finish
  task automatic settle();
    item_bus.valid <= 1'b0;
    while (metrics_pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // result ready with random stalls, calm stretches come and go
  initial begin : result_pull
    int stall;
    result_bus.ready = 1'b0;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(299) == 0) ready_calm = !ready_calm;
      if (stall > 0) begin
        result_bus.ready <= 1'b0;
        stall--;
      end else begin
        result_bus.ready <= 1'b1;
        stall = idle_len(ready_calm);
      end
    end
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int start_count, phase_end, r;
    item_bus.valid     = 1'b0;
    item_bus.command   = CMD_LOAD;
    item_bus.row_index = '0;
    item_bus.col_index = '0;
    item_bus.x_coord   = '0;
    item_bus.y_coord   = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = CFG_IDX_ROWS;
    cfg_bus.data       = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // smallest grid, checkerboard of extreme coordinates
    write_reg(CFG_IDX_ROWS, 7'd3);
    write_reg(CFG_IDX_COLS, 7'd3);
    write_reg(CFG_IDX_SPARE_A, 7'd127);
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        if ((j + k) % 2 == 0) drive_item(CMD_LOAD, j, k, CoordMax, CoordMin);
        else drive_item(CMD_LOAD, j, k, CoordMin, CoordMax);
      end
    end
    query_point(0, 0);
    query_point(1, 1);
    query_point(2, 2);
    query_point(0, 2);
    query_point(2, 0);
    // queries past the sizes in use
    query_point(3, 1);
    query_point(1, 3);
    query_point(63, 63);

    // sizes clamped from below and above
    settle();
    write_reg(CFG_IDX_ROWS, 7'd0);
    write_reg(CFG_IDX_COLS, 7'd127);
    write_reg(CFG_IDX_SPARE_B, 7'd0);
    drive_item(CMD_LOAD, 63, 63, CoordMax, CoordMin);
    query_point(1, 0);
    query_point(0, 63);
    query_point(2, 62);

    // random phases, each with its own sizes
    start_count = items_sent;
    while (items_sent - start_count < RandomItems) begin
      settle();
      write_reg(CFG_IDX_ROWS, pick_size());
      write_reg(CFG_IDX_COLS, pick_size());
      if ($urandom_range(3) == 0)
        write_reg($urandom_range(1) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B, CfgDataW'($urandom));
      items_calm = ($urandom_range(3) == 0);
      phase_end = items_sent + $urandom_range(100, 300);
      while (items_sent < phase_end && items_sent - start_count < RandomItems) begin
        r = $urandom_range(99);
        if (r < 55) begin
          query_point(pick_index(size_in_use(rows_raw, MaxRows)),
                      pick_index(size_in_use(cols_raw, MaxCols)));
        end else if (r < 70) begin
          query_point($urandom_range(MaxRows - 1), $urandom_range(MaxCols - 1));
        end else begin
          drive_item(CMD_LOAD, $urandom_range(MaxRows - 1), $urandom_range(MaxCols - 1),
                     rand_coord(), rand_coord());
        end
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
